/* sv/mail_header_unfolder_unit_macros.svh */
// Assertion macros for the mail header unfolder.
// Used by the top level only; no other dependencies.
`ifndef MAIL_HEADER_UNFOLDER_UNIT_MACROS_SVH
`define MAIL_HEADER_UNFOLDER_UNIT_MACROS_SVH

// same-cycle implication
`define MHU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MHU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mhu_pkg.sv */
// Shared types and constants for the mail header unfolder.
// No dependencies.
package mhu_pkg;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    SEL_SP      = 2'd0,
    SEL_RUN     = 2'd1,
    SEL_TXT_IN  = 2'd2,
    SEL_TXT_REG = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic is_ws;
    logic is_nl;
    logic is_nul;
    logic started;
    logic has_nl;
    logic run_nz;
    logic run_full;
    logic flush_last;
    logic txt_last;
    logic slot;
  } status_t;

  typedef struct packed {
    logic      in_ready;
    logic      ws_store;
    logic      ws_nl;
    logic      ovf_set;
    logic      latch_text;
    logic      start_text;
    logic      rd_first;
    logic      rd_next;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
    logic      clear_run;
    logic      clear_all;
  } cmd_t;

endpackage

/* sv/mhu_in_if.sv */
// Input channel of the mail header unfolder: one raw header byte per item.
// No dependencies.
interface mhu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/mhu_out_if.sv */
// Result channel of the mail header unfolder: one unfolded byte per item.
// No dependencies.
interface mhu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       run_overflow;

  modport source (output valid, output out_byte, output out_last, output run_overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input run_overflow,
                  output ready);
endinterface

/* sv/mhu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mhu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/mhu_ctrl.sv */
// Controller of the mail header unfolder: sequences accept, run flush,
// text byte and closing space. Depends on mhu_pkg.
module mhu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  mhu_pkg::status_t sts,
  output mhu_pkg::cmd_t    cmd
);
  import mhu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_TEXT  = 4'b0100,
    ST_CLOSE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   fire;

  // input is offered only in ST_IDLE, where ready equals the output slot
  assign fire = sts.in_valid && sts.slot;

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = SEL_SP;
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = sts.slot;
        if (fire) begin
          if (sts.in_last && (sts.is_ws || sts.is_nul)) begin
            cmd.emit      = sts.started;
            cmd.emit_sel  = SEL_SP;
            cmd.emit_last = 1'b1;
            cmd.clear_all = 1'b1;
          end else if (sts.is_ws) begin
            if (sts.started) begin
              if (sts.is_nl) begin
                cmd.ws_nl = 1'b1;
              end else if (!sts.has_nl) begin
                cmd.ws_store = !sts.run_full;
                cmd.ovf_set  = sts.run_full;
              end
            end
          end else begin
            cmd.latch_text = 1'b1;
            cmd.start_text = 1'b1;
            if (sts.started && sts.has_nl) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = SEL_SP;
              state_nxt    = ST_TEXT;
            end else if (sts.started && sts.run_nz) begin
              cmd.rd_first = 1'b1;
              state_nxt    = ST_FLUSH;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = SEL_TXT_IN;
              cmd.clear_run = 1'b1;
              state_nxt     = sts.in_last ? ST_CLOSE : ST_IDLE;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (sts.slot) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_RUN;
          if (sts.flush_last) begin
            state_nxt = ST_TEXT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_TEXT: begin
        if (sts.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_TXT_REG;
          cmd.clear_run = 1'b1;
          state_nxt     = sts.txt_last ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (sts.slot) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_SP;
          cmd.emit_last = 1'b1;
          cmd.clear_all = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/mhu_datapath.sv */
// Datapath of the mail header unfolder: header state, whitespace run buffer
// and output register. Depends on mhu_pkg, mhu_in_if, mhu_out_if, mhu_ram.
module mhu_datapath #(
  parameter int RUN_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mhu_in_if.sink           in_ch,
  mhu_out_if.source        out_ch,
  input  mhu_pkg::cmd_t    cmd,
  output mhu_pkg::status_t sts
);
  import mhu_pkg::*;

  localparam int AW = $clog2(RUN_DEPTH);
  localparam int LW = $clog2(RUN_DEPTH + 1);

  logic          started_r, started_nxt;
  logic          nl_r, nl_nxt;
  logic          ovf_r, ovf_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] idx_r;
  logic [7:0]    txt_r;
  logic          txt_last_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_ovf_r;

  logic [AW-1:0] rd_addr;
  logic          rd_bit;
  logic          tab_bit;
  logic [7:0]    emit_byte;

  assign tab_bit = (in_ch.in_byte == CH_TAB);
  assign rd_addr = cmd.rd_first ? '0 : AW'(idx_r + 1'b1);

  mhu_ram #(
    .WIDTH (1),
    .DEPTH (RUN_DEPTH)
  ) u_run_ram (
    .clk     (clk),
    .wr_en   (cmd.ws_store),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (tab_bit),
    .rd_en   (cmd.rd_first || cmd.rd_next),
    .rd_addr (rd_addr),
    .rd_data (rd_bit)
  );

  always_comb begin
    sts.in_valid   = in_ch.valid;
    sts.in_last    = in_ch.in_last;
    sts.is_nl      = (in_ch.in_byte == CH_NL);
    sts.is_ws      = (in_ch.in_byte == CH_SP) || tab_bit || sts.is_nl;
    sts.is_nul     = (in_ch.in_byte == CH_NUL);
    sts.started    = started_r;
    sts.has_nl     = nl_r;
    sts.run_nz     = (len_r != '0);
    sts.run_full   = (len_r == LW'(RUN_DEPTH));
    sts.flush_last = ((LW'(idx_r) + LW'(1)) == len_r);
    sts.txt_last   = txt_last_r;
    sts.slot       = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    case (cmd.emit_sel)
      SEL_SP:      emit_byte = CH_SP;
      SEL_RUN:     emit_byte = rd_bit ? CH_TAB : CH_SP;
      SEL_TXT_IN:  emit_byte = in_ch.in_byte;
      SEL_TXT_REG: emit_byte = txt_r;
      default:     emit_byte = CH_SP;
    endcase
  end

  always_comb begin
    started_nxt = started_r;
    nl_nxt      = nl_r;
    ovf_nxt     = ovf_r;
    len_nxt     = len_r;
    if (cmd.start_text) started_nxt = 1'b1;
    if (cmd.ws_nl)      nl_nxt      = 1'b1;
    if (cmd.ovf_set)    ovf_nxt     = 1'b1;
    if (cmd.ws_store)   len_nxt     = len_r + 1'b1;
    if (cmd.clear_run || cmd.clear_all) begin
      nl_nxt  = 1'b0;
      len_nxt = '0;
    end
    if (cmd.clear_all) begin
      started_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      nl_r        <= 1'b0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      nl_r      <= nl_nxt;
      ovf_r     <= ovf_nxt;
      len_r     <= len_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx_r <= '0;
    end else if (cmd.rd_next) begin
      idx_r <= rd_addr;
    end
    if (cmd.latch_text) begin
      txt_r      <= in_ch.in_byte;
      txt_last_r <= in_ch.in_last;
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.emit_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign in_ch.ready         = cmd.in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.out_last     = out_last_r;
  assign out_ch.run_overflow = out_ovf_r;

endmodule

/* sv/mail_header_unfolder_unit.sv */
// Mail header unfolder top level: controller plus datapath, item channels.
// A plain text byte shows at the output in the cycle after its accept.
// Whitespace and plain text bytes are taken as the output register frees; a text
// byte after a buffered run is handled as accept, run RAM reads, the byte; after
// a newline run as one space, then the byte; a last text byte adds a closing space.
// Synchronous active-low reset clears header state and the controller.
`include "mail_header_unfolder_unit_macros.svh"
module mail_header_unfolder_unit #(
  parameter int RUN_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  mhu_in_if.sink    in_ch,
  mhu_out_if.source out_ch
);
  import mhu_pkg::*;

  status_t sts;
  cmd_t    cmd;

  mhu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mhu_datapath #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  `MHU_ASSERT_IMP(a_accept_slot, clk, rst_n, in_ch.ready, !out_ch.valid || out_ch.ready, "item accepted with output register full")
  `MHU_ASSERT_NXT(a_close_clears, clk, rst_n, cmd.emit && cmd.emit_last, !sts.started && !sts.run_nz && !sts.has_nl, "header state not cleared after closing space")
  `MHU_ASSERT_NXT(a_flush_busy, clk, rst_n, cmd.rd_first, !in_ch.ready, "input accepted during run flush")

endmodule

/* sim/mail_header_unfolder_unit_test.sv */
// Testbench for mail_header_unfolder_unit: drives folded header bytes, predicts
// the unfolded byte stream in-line and checks every result item in order.
// Depends on mhu_pkg, mhu_in_if, mhu_out_if and the top level.
module mail_header_unfolder_unit_test;
  import mhu_pkg::*;

  localparam int RUN_DEPTH   = 32;
  localparam int ITEM_TARGET = 380;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       cut;
  } unfolded_t;

  logic clk = 1'b0;
  logic rst_n;

  mhu_in_if  hdr_in ();
  mhu_out_if hdr_out ();

  mail_header_unfolder_unit #(.RUN_DEPTH(RUN_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (hdr_in),
    .out_ch (hdr_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unfolded_t unfolded_q[$];
  int        error_count = 0;
  int        sent_count = 0;
  int        out_wait = 0;
  int        idle_cycles = 0;
  bit        quiet_in = 1'b0;
  bit        quiet_out = 1'b0;

  // predictor state
  bit         hdr_started;
  int         ws_count;
  bit         ws_folded;
  bit         ws_tab[RUN_DEPTH];
  bit         cut_seen;

  function automatic void clear_header();
    hdr_started = 1'b0;
    ws_count    = 0;
    ws_folded   = 1'b0;
    cut_seen    = 1'b0;
  endfunction

  function automatic void push_char(logic [7:0] c, logic l);
    unfolded_t u;
    u.ch   = c;
    u.last = l;
    u.cut  = cut_seen;
    unfolded_q.push_back(u);
  endfunction

  function automatic void predict_unfold(logic [7:0] b, logic l);
    bit sp_tab;
    bit ws;
    sp_tab = (b == CH_SP) || (b == CH_TAB);
    ws     = sp_tab || (b == CH_NL);
    if (l && (ws || b == CH_NUL)) begin
      if (hdr_started) push_char(CH_SP, 1'b1);
      clear_header();
      return;
    end
    if (ws) begin
      if (!hdr_started) return;
      if (b == CH_NL) begin
        ws_folded = 1'b1;
      end else if (!ws_folded) begin
        if (ws_count < RUN_DEPTH) begin
          ws_tab[ws_count] = (b == CH_TAB);
          ws_count++;
        end else begin
          cut_seen = 1'b1;
        end
      end
      return;
    end
    if (hdr_started) begin
      if (ws_folded) begin
        push_char(CH_SP, 1'b0);
      end else begin
        for (int i = 0; i < ws_count; i++) push_char(ws_tab[i] ? CH_TAB : CH_SP, 1'b0);
      end
    end
    ws_count    = 0;
    ws_folded   = 1'b0;
    hdr_started = 1'b1;
    push_char(b, 1'b0);
    if (l) begin
      push_char(CH_SP, 1'b1);
      clear_header();
    end
  endfunction

  function automatic int idle_draw(bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  function automatic void check_result();
    unfolded_t exp_item;
    if (unfolded_q.size() == 0) begin
      $display("%0t unexpected item: out_byte %h out_last %b run_overflow %b", $time,
               hdr_out.out_byte, hdr_out.out_last, hdr_out.run_overflow);
      error_count++;
      return;
    end
    exp_item = unfolded_q.pop_front();
    if (hdr_out.out_byte !== exp_item.ch) begin
      $display("%0t out_byte mismatch: expected %h actual %h", $time, exp_item.ch,
               hdr_out.out_byte);
      error_count++;
    end
    if (hdr_out.out_last !== exp_item.last) begin
      $display("%0t out_last mismatch: expected %b actual %b", $time, exp_item.last,
               hdr_out.out_last);
      error_count++;
    end
    if (hdr_out.run_overflow !== exp_item.cut) begin
      $display("%0t run_overflow mismatch: expected %b actual %b", $time, exp_item.cut,
               hdr_out.run_overflow);
      error_count++;
    end
  endfunction

  // result side: check each item, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst_n && hdr_out.valid && hdr_out.ready) begin
      check_result();
      out_wait = idle_draw(quiet_out);
    end
    if (out_wait > 0) begin
      hdr_out.ready <= 1'b0;
      out_wait--;
    end else begin
      hdr_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((hdr_in.valid && hdr_in.ready) || (hdr_out.valid && hdr_out.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = idle_draw(quiet_in);
    if (gap > 0) begin
      hdr_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hdr_in.valid   <= 1'b1;
    hdr_in.in_byte <= b;
    hdr_in.in_last <= l;
    @(posedge clk);
    while (!hdr_in.ready) @(posedge clk);
    predict_unfold(b, l);
    sent_count++;
  endtask

  task automatic send_str(input string s, input bit end_hdr);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_hdr && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    while (unfolded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SP || b == CH_TAB || b == CH_NL);
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CH_TAB : CH_SP;
  endfunction

  task automatic send_blank_run(input int n);
    for (int i = 0; i < n; i++) send_byte(pick_blank(), 1'b0);
  endtask

  task automatic test_basic_folding();
    send_str(" \t\nA", 1'b0);
    send_str(" \t B", 1'b0);
    send_str(" \n\t C", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_str(" \t", 1'b0);
    send_byte(CH_NUL, 1'b1);
    send_str(" \n", 1'b0);
    send_byte(CH_NUL, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_str("z", 1'b0);
    send_byte(CH_NL, 1'b1);
    send_byte(CH_SP, 1'b1);
  endtask

  task automatic test_run_overflow();
    send_str("t", 1'b0);
    send_blank_run(RUN_DEPTH - 1);
    send_str("u", 1'b0);
    send_blank_run(RUN_DEPTH);
    send_str("v", 1'b1);
    send_str("w", 1'b0);
    send_blank_run(RUN_DEPTH + 1);
    send_str("x", 1'b0);
    send_blank_run(2);
    send_str("y", 1'b1);
    // cut flag must not leak into the next header
    send_str("a", 1'b0);
    send_blank_run(RUN_DEPTH + 2);
    send_byte(CH_NL, 1'b0);
    send_blank_run(6);
    send_str("b", 1'b0);
    send_blank_run(RUN_DEPTH + 6);
    send_byte(CH_TAB, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_str("Subj:  one\n two", 1'b1);
    hdr_in.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    send_str("To:\t x ", 1'b1);
  endtask

  task automatic send_random_header();
    logic [7:0] hdr[$];
    int words;
    int kind;
    for (int i = $urandom_range(0, 3); i > 0; i--)
      hdr.push_back($urandom_range(0, 2) == 0 ? CH_NL : pick_blank());
    words = $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      for (int i = $urandom_range(1, 5); i > 0; i--) hdr.push_back(pick_text());
      if (w == words - 1) break;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        for (int i = $urandom_range(1, 4); i > 0; i--) hdr.push_back(pick_blank());
      end else if (kind < 9) begin
        for (int i = $urandom_range(0, 2); i > 0; i--) hdr.push_back(pick_blank());
        hdr.push_back(CH_NL);
        for (int i = $urandom_range(0, 2); i > 0; i--) hdr.push_back(pick_blank());
      end else begin
        for (int i = $urandom_range(RUN_DEPTH - 4, RUN_DEPTH + 4); i > 0; i--)
          hdr.push_back(pick_blank());
      end
    end
    kind = $urandom_range(0, 4);
    if (kind != 0)
      for (int i = $urandom_range(0, 3); i > 0; i--) hdr.push_back(pick_blank());
    case (kind)
      0: hdr.push_back(pick_text());
      1: hdr.push_back(CH_NUL);
      2: hdr.push_back(CH_NL);
      3: hdr.push_back(CH_SP);
      default: hdr.push_back(CH_TAB);
    endcase
    foreach (hdr[i]) send_byte(hdr[i], i == hdr.size() - 1);
  endtask

  task automatic send_noise();
    for (int i = $urandom_range(1, 8); i > 0; i--)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_random_headers();
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) quiet_in = ~quiet_in;
      if ($urandom_range(0, 5) == 0) quiet_out = ~quiet_out;
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_random_header();
    end
    send_byte(pick_text(), 1'b1);
  endtask

  initial begin
    clear_header();
    rst_n          <= 1'b0;
    hdr_in.valid   <= 1'b0;
    hdr_in.in_byte <= 8'h00;
    hdr_in.in_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_folding();
    test_run_overflow();
    test_drain_pause();
    test_random_headers();

    hdr_in.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && unfolded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/mhu_pkg.sv
sv/mhu_in_if.sv
sv/mhu_out_if.sv
sv/mhu_ram.sv
sv/mhu_ctrl.sv
sv/mhu_datapath.sv
sv/mail_header_unfolder_unit.sv
sim/mail_header_unfolder_unit_test.sv
